// ----- src/i2a_pkg.sv -----
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, codes, constants and helpers of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

	localparam int VALUE_BITS_DEF  = 64;
	localparam int DIGIT_DEPTH_DEF = 32;
	localparam int CHUNK_BITS      = 8;

	localparam int FUNC_BITS   = 3;
	localparam int LENGTH_BITS = 2;
	localparam int ARG_BITS    = 64;
	localparam int CHAR_BITS   = 8;
	localparam int DIGIT_BITS  = 4;

	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic REG_LONG_IS_WIDE = 1'b0;
	localparam logic LONG_IS_WIDE_RESET = 1'b1;

	localparam logic [FUNC_BITS-1:0] FUNC_SDEC = 3'd0;
	localparam logic [FUNC_BITS-1:0] FUNC_UDEC = 3'd1;
	localparam logic [FUNC_BITS-1:0] FUNC_HEXL = 3'd2;
	localparam logic [FUNC_BITS-1:0] FUNC_HEXU = 3'd3;
	localparam logic [FUNC_BITS-1:0] FUNC_OCT  = 3'd4;
	localparam logic [FUNC_BITS-1:0] FUNC_PTR  = 3'd5;
	localparam logic [FUNC_BITS-1:0] FUNC_CHR  = 3'd6;
	localparam logic [FUNC_BITS-1:0] FUNC_BAD  = 3'd7;

	localparam logic [LENGTH_BITS-1:0] LEN_INT  = 2'd0;
	localparam logic [LENGTH_BITS-1:0] LEN_LONG = 2'd1;

	localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2d;
	localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_BITS-1:0] CH_X       = 8'h78;
	localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;

	localparam logic [4:0] DEC_RADIX = 5'd10;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_HEX,
		RADIX_OCT
	} radix_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIGN,
		ST_PFX0,
		ST_PFX1,
		ST_CHAR,
		ST_DIV,
		ST_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		radix_t                radix;
		logic [DIGIT_BITS-1:0] part;
	} div_ctl_t;

	function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d,
		input logic upper);
		logic [CHAR_BITS-1:0] base;
		base = upper ? CH_UPPER_A : CH_LOWER_A;
		if (d < 4'd10) begin
			return CH_ZERO + {4'b0, d};
		end
		return base + {4'b0, d} - 8'd10;
	endfunction

endpackage

`default_nettype wire

// ----- src/i2a_if.sv -----
// ----------------------------------------------------------------------------
// i2a_if
// Request channels of the formatter: the argument side and the text side.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2a_arg_if;
	logic                              valid;
	logic                              ready;
	logic [i2a_pkg::FUNC_BITS-1:0]     func;
	logic [i2a_pkg::LENGTH_BITS-1:0]   length_kind;
	logic [i2a_pkg::ARG_BITS-1:0]      value;

	modport source(output valid, func, length_kind, value, input ready);
	modport sink(input valid, func, length_kind, value, output ready);
endinterface

interface i2a_text_if;
	logic                            valid;
	logic                            ready;
	logic [i2a_pkg::CHAR_BITS-1:0]   out_char;
	logic                            last;

	modport source(output valid, out_char, last, input ready);
	modport sink(input valid, out_char, last, output ready);
endinterface

`default_nettype wire

// ----- src/i2a_ram.sv -----
// ----------------------------------------------------------------------------
// i2a_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/i2a_div_unit.sv -----
// ----------------------------------------------------------------------------
// i2a_div_unit
// Shared divide step: eight bits of long division by ten, or one hex or octal
// digit peeled off by a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_div_unit #(
	parameter int PAD_BITS = 64
) (
	input  wire i2a_pkg::div_ctl_t                   ctl,
	input  wire logic [PAD_BITS-1:0]                 rem_i,
	output logic      [PAD_BITS-1:0]                 rem_o,
	output logic      [i2a_pkg::DIGIT_BITS-1:0]      part_o
);

	localparam int CB = i2a_pkg::CHUNK_BITS;

	logic [CB-1:0]                  chunk;
	logic [CB-1:0]                  qbits;
	logic [i2a_pkg::DIGIT_BITS:0]   acc;
	logic [i2a_pkg::DIGIT_BITS-1:0] p;

	always_comb begin
		chunk  = rem_i[PAD_BITS-1 -: CB];
		qbits  = '0;
		acc    = '0;
		p      = ctl.part;
		rem_o  = rem_i;
		part_o = '0;
		case (ctl.radix)
			i2a_pkg::RADIX_DEC: begin
				for (int i = CB - 1; i >= 0; i--) begin
					acc = {p, chunk[i]};
					if (acc >= i2a_pkg::DEC_RADIX) begin
						acc      = acc - i2a_pkg::DEC_RADIX;
						qbits[i] = 1'b1;
					end
					p = acc[i2a_pkg::DIGIT_BITS-1:0];
				end
				rem_o  = {rem_i[PAD_BITS-CB-1:0], qbits};
				part_o = p;
			end
			i2a_pkg::RADIX_HEX: begin
				rem_o  = rem_i >> 4;
				part_o = rem_i[3:0];
			end
			i2a_pkg::RADIX_OCT: begin
				rem_o  = rem_i >> 3;
				part_o = {1'b0, rem_i[2:0]};
			end
			default: begin
				rem_o  = rem_i;
				part_o = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- src/i2a_seq.sv -----
// ----------------------------------------------------------------------------
// i2a_seq
// Sequencer of the formatter: sign, prefix and single characters, the divide loop
// into the digit store, and readout of the store in reverse order.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_seq #(
	parameter int VALUE_BITS  = i2a_pkg::VALUE_BITS_DEF,
	parameter int DIGIT_DEPTH = i2a_pkg::DIGIT_DEPTH_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   long_is_wide,
	i2a_arg_if.sink     arg,
	i2a_text_if.source  text
);

	localparam int STEPS     = (VALUE_BITS + i2a_pkg::CHUNK_BITS - 1) / i2a_pkg::CHUNK_BITS;
	localparam int PAD_BITS  = STEPS * i2a_pkg::CHUNK_BITS;
	localparam int STEP_BITS = $clog2(STEPS);
	localparam int IDX_BITS  = $clog2(DIGIT_DEPTH);
	localparam int CNT_BITS  = $clog2(DIGIT_DEPTH + 1);
	localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(STEPS - 1);

	i2a_pkg::state_t state_q, state_d;
	i2a_pkg::radix_t radix_q, radix_sel;

	logic [PAD_BITS-1:0]              rem_q;
	logic [PAD_BITS-1:0]              rem_o;
	logic [CNT_BITS-1:0]              cnt_q;
	logic [CNT_BITS-1:0]              cnt_m1;
	logic [STEP_BITS-1:0]             step_q;
	logic [i2a_pkg::DIGIT_BITS-1:0]   part_q;
	logic [i2a_pkg::DIGIT_BITS-1:0]   part_o;
	logic [i2a_pkg::DIGIT_BITS-1:0]   rdata;
	logic                             upper_q;
	logic                             ov_q;
	logic [i2a_pkg::CHAR_BITS-1:0]    oc_q;
	logic                             ol_q;
	i2a_pkg::div_ctl_t                div_ctl;

	logic                             wide;
	logic [VALUE_BITS-1:0]            vin;
	logic [VALUE_BITS-1:0]            mask;
	logic [VALUE_BITS-1:0]            vm;
	logic [VALUE_BITS-1:0]            mag;
	logic                             neg;
	logic                             digit_done;
	logic                             load_ok;
	logic                             ld;
	logic [i2a_pkg::CHAR_BITS-1:0]    ld_char;
	logic                             ld_last;
	logic                             we;
	logic                             re;

	always_comb begin
		if (arg.length_kind == i2a_pkg::LEN_INT) begin
			wide = 1'b0;
		end else if (arg.length_kind == i2a_pkg::LEN_LONG) begin
			wide = long_is_wide;
		end else begin
			wide = 1'b1;
		end
		if (arg.func == i2a_pkg::FUNC_PTR) begin
			wide = 1'b1;
		end
		vin = arg.value[VALUE_BITS-1:0];
		for (int i = 0; i < VALUE_BITS; i++) begin
			mask[i] = wide || (i < 32);
		end
		vm  = vin & mask;
		neg = (arg.func == i2a_pkg::FUNC_SDEC) && (wide ? vm[VALUE_BITS-1] : vm[31]);
		mag = neg ? ((~vm + 1'b1) & mask) : vm;
		case (arg.func)
			i2a_pkg::FUNC_HEXL, i2a_pkg::FUNC_HEXU, i2a_pkg::FUNC_PTR: radix_sel = i2a_pkg::RADIX_HEX;
			i2a_pkg::FUNC_OCT: radix_sel = i2a_pkg::RADIX_OCT;
			default:           radix_sel = i2a_pkg::RADIX_DEC;
		endcase
	end

	assign div_ctl.radix = radix_q;
	assign div_ctl.part  = part_q;

	i2a_div_unit #(
		.PAD_BITS(PAD_BITS)
	) u_div (
		.ctl    (div_ctl),
		.rem_i  (rem_q),
		.rem_o  (rem_o),
		.part_o (part_o)
	);

	i2a_ram #(
		.WIDTH(i2a_pkg::DIGIT_BITS),
		.DEPTH(DIGIT_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[IDX_BITS-1:0]),
		.wdata (part_o),
		.re    (re),
		.raddr (cnt_m1[IDX_BITS-1:0]),
		.rdata (rdata)
	);

	assign digit_done = (radix_q != i2a_pkg::RADIX_DEC) || (step_q == LAST_STEP);
	assign load_ok    = !ov_q || text.ready;
	assign cnt_m1     = cnt_q - 1'b1;

	always_comb begin
		state_d = state_q;
		case (state_q)
			i2a_pkg::ST_IDLE: begin
				if (arg.valid) begin
					if (arg.func == i2a_pkg::FUNC_SDEC) begin
						state_d = neg ? i2a_pkg::ST_SIGN : i2a_pkg::ST_DIV;
					end else if (arg.func inside {i2a_pkg::FUNC_UDEC, i2a_pkg::FUNC_HEXL,
						i2a_pkg::FUNC_HEXU, i2a_pkg::FUNC_OCT}) begin
						state_d = i2a_pkg::ST_DIV;
					end else if (arg.func == i2a_pkg::FUNC_PTR) begin
						state_d = i2a_pkg::ST_PFX0;
					end else if (arg.func == i2a_pkg::FUNC_CHR) begin
						state_d = i2a_pkg::ST_CHAR;
					end
				end
			end
			i2a_pkg::ST_SIGN: if (load_ok) state_d = i2a_pkg::ST_DIV;
			i2a_pkg::ST_PFX0: if (load_ok) state_d = i2a_pkg::ST_PFX1;
			i2a_pkg::ST_PFX1: if (load_ok) state_d = i2a_pkg::ST_DIV;
			i2a_pkg::ST_CHAR: if (load_ok) state_d = i2a_pkg::ST_IDLE;
			i2a_pkg::ST_DIV: begin
				if (digit_done && rem_o == '0) begin
					state_d = i2a_pkg::ST_RD;
				end
			end
			i2a_pkg::ST_RD: state_d = i2a_pkg::ST_EMIT;
			i2a_pkg::ST_EMIT: begin
				if (load_ok && cnt_q == '0) begin
					state_d = i2a_pkg::ST_IDLE;
				end
			end
			default: state_d = i2a_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		arg.ready = (state_q == i2a_pkg::ST_IDLE);
		ld        = 1'b0;
		ld_char   = i2a_pkg::CH_ZERO;
		ld_last   = 1'b0;
		we        = 1'b0;
		re        = 1'b0;
		case (state_q)
			i2a_pkg::ST_SIGN: begin
				ld      = load_ok;
				ld_char = i2a_pkg::CH_MINUS;
			end
			i2a_pkg::ST_PFX0: begin
				ld      = load_ok;
				ld_char = i2a_pkg::CH_ZERO;
			end
			i2a_pkg::ST_PFX1: begin
				ld      = load_ok;
				ld_char = i2a_pkg::CH_X;
			end
			i2a_pkg::ST_CHAR: begin
				ld      = load_ok;
				ld_char = rem_q[i2a_pkg::CHAR_BITS-1:0];
				ld_last = 1'b1;
			end
			i2a_pkg::ST_DIV: we = digit_done;
			i2a_pkg::ST_RD: re = 1'b1;
			i2a_pkg::ST_EMIT: begin
				ld      = load_ok;
				ld_char = i2a_pkg::digit_char(rdata, upper_q);
				ld_last = (cnt_q == '0);
				re      = load_ok && (cnt_q != '0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= i2a_pkg::ST_IDLE;
			rem_q   <= '0;
			cnt_q   <= '0;
			step_q  <= '0;
			part_q  <= '0;
			radix_q <= i2a_pkg::RADIX_DEC;
			upper_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld) begin
				ov_q <= 1'b1;
			end else if (text.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				i2a_pkg::ST_IDLE: begin
					if (arg.valid) begin
						if (arg.func == i2a_pkg::FUNC_CHR) begin
							rem_q <= PAD_BITS'(arg.value[i2a_pkg::CHAR_BITS-1:0]);
						end else begin
							rem_q <= PAD_BITS'(mag);
						end
						cnt_q   <= '0;
						step_q  <= '0;
						part_q  <= '0;
						radix_q <= radix_sel;
						upper_q <= (arg.func == i2a_pkg::FUNC_HEXU);
					end
				end
				i2a_pkg::ST_DIV: begin
					rem_q <= rem_o;
					if (digit_done) begin
						cnt_q  <= cnt_q + 1'b1;
						step_q <= '0;
						part_q <= '0;
					end else begin
						step_q <= step_q + 1'b1;
						part_q <= part_o;
					end
				end
				i2a_pkg::ST_RD: cnt_q <= cnt_m1;
				i2a_pkg::ST_EMIT: begin
					if (load_ok && cnt_q != '0) begin
						cnt_q <= cnt_m1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			oc_q <= ld_char;
			ol_q <= ld_last;
		end
	end

	assign text.valid    = ov_q;
	assign text.out_char = oc_q;
	assign text.last     = ol_q;

	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2a_pkg::ST_DIV) |-> (cnt_q < CNT_BITS'(DIGIT_DEPTH)))
		else $error("digit store index out of range");

	a_bad_func: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2a_pkg::ST_IDLE && arg.valid && arg.func == i2a_pkg::FUNC_BAD)
		|=> (state_q == i2a_pkg::ST_IDLE))
		else $error("unused kind code left the idle state");

	a_div_to_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2a_pkg::ST_DIV && digit_done && rem_o == '0)
		|=> (state_q == i2a_pkg::ST_RD && cnt_q != '0))
		else $error("divide loop finished without a stored digit");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2a_pkg::ST_EMIT && ld && ld_last) |=> (state_q == i2a_pkg::ST_IDLE))
		else $error("readout went on past the last digit");

endmodule

`default_nettype wire

// ----- src/integer_to_ascii_formatter.sv -----
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Printf-style integer conversion of one argument into ASCII characters.
// ----------------------------------------------------------------------------
// Hex and octal peel one digit per divide step; the pointer kind also emits the 0x prefix.
// Decimal runs the long division over the whole value for each digit, after any minus sign,
// since the shared divide unit handles eight bits of the value a cycle.
// Sign, prefix and character output pass the state register and the output register;
// digits pass the read state, the registered store read and the output register.
// Reset is asynchronous: idle, long_is_wide back to 1, the digit store keeps its contents.
`default_nettype none

module integer_to_ascii_formatter #(
	parameter int VALUE_BITS  = i2a_pkg::VALUE_BITS_DEF,
	parameter int DIGIT_DEPTH = i2a_pkg::DIGIT_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [i2a_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  wire logic [i2a_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic      [i2a_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                      pready,
	i2a_arg_if.sink                                   arg,
	i2a_text_if.source                                text
);

	logic long_is_wide_q;
	logic reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[2] == i2a_pkg::REG_LONG_IS_WIDE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_is_wide_q <= i2a_pkg::LONG_IS_WIDE_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			long_is_wide_q <= pwdata[0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_hit) begin
			prdata[0] = long_is_wide_q;
		end
	end

	i2a_seq #(
		.VALUE_BITS (VALUE_BITS),
		.DIGIT_DEPTH(DIGIT_DEPTH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.long_is_wide (long_is_wide_q),
		.arg          (arg),
		.text         (text)
	);

endmodule

`default_nettype wire
